// ===== rtl/isqs_pkg.sv =====
// ----------------------------------------------------------------------------
// isqs_pkg
// Shared types and constants of the index sort quicksort unit.
// ----------------------------------------------------------------------------
package isqs_pkg;

   localparam int MAX_KEYS_DEF  = 64;
   localparam int CUTOFF_DEF    = 7;
   localparam int STACK_DEF     = 16;
   localparam int KEY_W         = 32;
   localparam int POS_W         = 6;
   localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE,
      ST_INIT,
      ST_TEST,
      // median of three
      ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
      // partition scans
      ST_INC_I, ST_CHK_I, ST_DEC_J, ST_CHK_J, ST_CROSS,
      // pivot placement and push
      ST_F0, ST_F1, ST_F2, ST_F3, ST_F4,
      // insertion sort
      ST_IN0, ST_IN1, ST_IN2, ST_IN3, ST_IN4,
      // stack pop
      ST_POP0, ST_POP1, ST_POP2,
      // compare routine
      ST_CMP0, ST_CMP1, ST_CMP2, ST_CMP3,
      // swap routine
      ST_SWP0, ST_SWP1, ST_SWP2, ST_SWP3,
      // result output
      ST_OUT0, ST_OUT1
   } state_type;

endpackage

// ===== rtl/index_sort_quicksort_unit.sv =====
// ----------------------------------------------------------------------------
// index_sort_quicksort_unit
// Loads signed keys and emits their load positions in sorted order.
// ----------------------------------------------------------------------------
// Keys load at one per cycle while the unit is idle. The transaction marked last
// starts the sort: busy stays high for the whole sort and output phase. The
// index is set to the identity, sorted by a median-of-three quicksort with an
// explicit range stack and insertion sort for small ranges, then read out one
// result at a time. All work runs through single-port-read memories with
// registered read data, so each key compare reads two order entries and two
// keys in turn, and each swap reads two order entries and writes them back.
// Results appear on rsp_strobe for one cycle each and
// cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module index_sort_quicksort_unit #(
   parameter int MAX_KEYS         = isqs_pkg::MAX_KEYS_DEF,
   parameter int INSERTION_CUTOFF = isqs_pkg::CUTOFF_DEF,
   parameter int STACK_DEPTH      = isqs_pkg::STACK_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [isqs_pkg::KEY_W-1:0] req_key,
   input  logic                             req_last_key,
   output logic                             rsp_strobe,
   output logic        [isqs_pkg::POS_W-1:0] rsp_position,
   output logic                             rsp_last_position,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_descending
);

   localparam int AW  = $clog2(MAX_KEYS);
   localparam int IW  = AW + 1;
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SW  = SAW + 1;
   localparam int KW  = isqs_pkg::KEY_W;

   // memories
   logic [KW-1:0]  key_mem [MAX_KEYS];
   logic [AW-1:0]  ord_mem [MAX_KEYS];
   logic [AW-1:0]  stk_mem [STACK_DEPTH];

   logic           key_we;
   logic [AW-1:0]  key_waddr, key_raddr;
   logic [KW-1:0]  key_wdata, key_q_ff;
   logic           ord_we;
   logic [AW-1:0]  ord_waddr, ord_raddr, ord_wdata, ord_q_ff;
   logic           stk_we;
   logic [SAW-1:0] stk_waddr, stk_raddr;
   logic [AW-1:0]  stk_wdata, stk_q_ff;

   // control registers
   isqs_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic           desc_ff;
   logic [IW-1:0]  count_ff, count_in, n_ff, n_in, c_ff, c_in;
   logic [IW-1:0]  l_ff, l_in, r_ff, r_in, i_ff, i_in, j_ff, j_in;
   logic [IW-1:0]  jj_ff, jj_in, p_ff, p_in;
   logic [IW-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [SW-1:0]  sp_ff, sp_in;
   logic           by_idx_ff, by_idx_in;
   logic           gt_ff, gt_in, lt_ff, lt_in;
   // payload registers
   logic [AW-1:0]  cval_ff, cval_in, vx_ff, vx_in, tx_ff, tx_in;
   logic [AW-1:0]  a_ff, a_in, v_ff, v_in;
   logic [KW-1:0]  ka_ff, ka_in;
   logic [IW-1:0]  pl_ff, pl_in, ph_ff, ph_in;

   logic [IW-1:0]  span, ni, nj, kmid, cnt_next;
   logic [SW-1:0]  sp_p1;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != isqs_pkg::ST_IDLE);

   assign span  = r_ff - l_ff;
   assign ni    = i_ff + IW'(1);
   assign nj    = j_ff - IW'(1);
   assign kmid  = (l_ff + r_ff) >> 1;
   assign sp_p1 = sp_ff + SW'(1);
   assign cnt_next = (int'(count_ff) < MAX_KEYS) ? count_ff + IW'(1) : count_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      count_in  = count_ff;
      n_in      = n_ff;
      c_in      = c_ff;
      l_in      = l_ff;
      r_in      = r_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      jj_in     = jj_ff;
      p_in      = p_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      sp_in     = sp_ff;
      by_idx_in = by_idx_ff;
      gt_in     = gt_ff;
      lt_in     = lt_ff;
      cval_in   = cval_ff;
      vx_in     = vx_ff;
      tx_in     = tx_ff;
      a_in      = a_ff;
      v_in      = v_ff;
      ka_in     = ka_ff;
      pl_in     = pl_ff;
      ph_in     = ph_ff;

      key_we    = 1'b0;
      key_waddr = count_ff[AW-1:0];
      key_wdata = req_key ^ isqs_pkg::SIGN_FLIP;
      key_raddr = ord_q_ff;
      ord_we    = 1'b0;
      ord_waddr = c_ff[AW-1:0];
      ord_wdata = c_ff[AW-1:0];
      ord_raddr = cx_ff[AW-1:0];
      stk_we    = 1'b0;
      stk_waddr = sp_ff[SAW-1:0];
      stk_wdata = pl_ff[AW-1:0];
      stk_raddr = sp_ff[SAW-1:0];

      rsp_strobe        = 1'b0;
      rsp_position      = isqs_pkg::POS_W'(ord_q_ff);
      rsp_last_position = (c_ff + IW'(1) == n_ff);

      unique case (state_ff)
         isqs_pkg::ST_IDLE: begin
            if (start) begin
               key_we   = (int'(count_ff) < MAX_KEYS);
               count_in = cnt_next;
               if (req_last_key) begin
                  n_in     = cnt_next;
                  c_in     = '0;
                  state_in = isqs_pkg::ST_INIT;
               end
            end
         end
         isqs_pkg::ST_INIT: begin
            ord_we = 1'b1;
            c_in   = c_ff + IW'(1);
            if (c_ff + IW'(1) == n_ff) begin
               l_in     = '0;
               r_in     = n_ff - IW'(1);
               sp_in    = '0;
               state_in = isqs_pkg::ST_TEST;
            end
         end
         isqs_pkg::ST_TEST: begin
            if (int'(span) < INSERTION_CUTOFF || int'(span) < 2 ||
                int'(sp_ff) + 2 > STACK_DEPTH) begin
               jj_in    = l_ff + IW'(1);
               state_in = isqs_pkg::ST_IN0;
            end else begin
               cx_in    = kmid;
               cy_in    = l_ff + IW'(1);
               ret_in   = isqs_pkg::ST_P1;
               state_in = isqs_pkg::ST_SWP0;
            end
         end
         isqs_pkg::ST_P0: state_in = isqs_pkg::ST_P1;
         isqs_pkg::ST_P1: begin
            cx_in = l_ff + IW'(1); cy_in = r_ff; by_idx_in = 1'b1;
            ret_in = isqs_pkg::ST_P2; state_in = isqs_pkg::ST_CMP0;
         end
         isqs_pkg::ST_P2: begin
            cx_in = l_ff + IW'(1); cy_in = r_ff; ret_in = isqs_pkg::ST_P3;
            state_in = gt_ff ? isqs_pkg::ST_SWP0 : isqs_pkg::ST_P3;
         end
         isqs_pkg::ST_P3: begin
            cx_in = l_ff; cy_in = r_ff; by_idx_in = 1'b1;
            ret_in = isqs_pkg::ST_P4; state_in = isqs_pkg::ST_CMP0;
         end
         isqs_pkg::ST_P4: begin
            cx_in = l_ff; cy_in = r_ff; ret_in = isqs_pkg::ST_P5;
            state_in = gt_ff ? isqs_pkg::ST_SWP0 : isqs_pkg::ST_P5;
         end
         isqs_pkg::ST_P5: begin
            cx_in = l_ff + IW'(1); cy_in = l_ff; by_idx_in = 1'b1;
            ret_in = isqs_pkg::ST_P6; state_in = isqs_pkg::ST_CMP0;
         end
         isqs_pkg::ST_P6: begin
            cx_in = l_ff + IW'(1); cy_in = l_ff; ret_in = isqs_pkg::ST_P7;
            state_in = gt_ff ? isqs_pkg::ST_SWP0 : isqs_pkg::ST_P7;
         end
         isqs_pkg::ST_P7: begin
            i_in      = l_ff + IW'(1);
            j_in      = r_ff;
            ord_raddr = l_ff[AW-1:0];
            state_in  = isqs_pkg::ST_P8;
         end
         isqs_pkg::ST_P8: begin
            a_in     = ord_q_ff;
            state_in = isqs_pkg::ST_INC_I;
         end
         // scan i up while ord[i] < pivot
         isqs_pkg::ST_INC_I: begin
            i_in = ni;
            if (ni < r_ff) begin
               cx_in = ni; cval_in = a_ff; by_idx_in = 1'b0;
               ret_in = isqs_pkg::ST_CHK_I; state_in = isqs_pkg::ST_CMP0;
            end else begin
               state_in = isqs_pkg::ST_DEC_J;
            end
         end
         isqs_pkg::ST_CHK_I:
            state_in = lt_ff ? isqs_pkg::ST_INC_I : isqs_pkg::ST_DEC_J;
         // scan j down while ord[j] > pivot
         isqs_pkg::ST_DEC_J: begin
            j_in = nj;
            if (nj > l_ff) begin
               cx_in = nj; cval_in = a_ff; by_idx_in = 1'b0;
               ret_in = isqs_pkg::ST_CHK_J; state_in = isqs_pkg::ST_CMP0;
            end else begin
               state_in = isqs_pkg::ST_CROSS;
            end
         end
         isqs_pkg::ST_CHK_J:
            state_in = gt_ff ? isqs_pkg::ST_DEC_J : isqs_pkg::ST_CROSS;
         isqs_pkg::ST_CROSS: begin
            if (j_ff < i_ff) begin
               state_in = isqs_pkg::ST_F0;
            end else begin
               cx_in = i_ff; cy_in = j_ff;
               ret_in = isqs_pkg::ST_INC_I; state_in = isqs_pkg::ST_SWP0;
            end
         end
         // place pivot at j
         isqs_pkg::ST_F0: begin
            ord_raddr = j_ff[AW-1:0];
            state_in  = isqs_pkg::ST_F1;
         end
         isqs_pkg::ST_F1: begin
            ord_we    = 1'b1;
            ord_waddr = l_ff[AW-1:0];
            ord_wdata = ord_q_ff;
            state_in  = isqs_pkg::ST_F2;
         end
         isqs_pkg::ST_F2: begin
            ord_we    = 1'b1;
            ord_waddr = j_ff[AW-1:0];
            ord_wdata = a_ff;
            state_in  = isqs_pkg::ST_F3;
         end
         // push the larger side, continue on the smaller
         isqs_pkg::ST_F3: begin
            if (r_ff + IW'(1) - i_ff >= j_ff - l_ff) begin
               pl_in = i_ff;  ph_in = r_ff;
               stk_wdata = i_ff[AW-1:0];
               r_in  = j_ff - IW'(1);
            end else begin
               pl_in = l_ff;  ph_in = j_ff - IW'(1);
               stk_wdata = l_ff[AW-1:0];
               l_in  = i_ff;
            end
            stk_we   = 1'b1;
            state_in = isqs_pkg::ST_F4;
         end
         isqs_pkg::ST_F4: begin
            stk_we    = 1'b1;
            stk_waddr = sp_p1[SAW-1:0];
            stk_wdata = ph_ff[AW-1:0];
            sp_in     = sp_ff + SW'(2);
            state_in  = isqs_pkg::ST_TEST;
         end
         // insertion sort over [l..r]
         isqs_pkg::ST_IN0: begin
            if (jj_ff > r_ff) begin
               state_in = isqs_pkg::ST_POP0;
            end else begin
               ord_raddr = jj_ff[AW-1:0];
               state_in  = isqs_pkg::ST_IN1;
            end
         end
         isqs_pkg::ST_IN1: begin
            v_in     = ord_q_ff;
            p_in     = jj_ff;
            state_in = isqs_pkg::ST_IN2;
         end
         isqs_pkg::ST_IN2: begin
            if (p_ff > l_ff) begin
               cx_in = p_ff - IW'(1); cval_in = v_ff; by_idx_in = 1'b0;
               ret_in = isqs_pkg::ST_IN3; state_in = isqs_pkg::ST_CMP0;
            end else begin
               state_in = isqs_pkg::ST_IN4;
            end
         end
         isqs_pkg::ST_IN3: begin
            if (gt_ff) begin
               ord_we    = 1'b1;
               ord_waddr = p_ff[AW-1:0];
               ord_wdata = vx_ff;
               p_in      = p_ff - IW'(1);
               state_in  = isqs_pkg::ST_IN2;
            end else begin
               state_in  = isqs_pkg::ST_IN4;
            end
         end
         isqs_pkg::ST_IN4: begin
            ord_we    = 1'b1;
            ord_waddr = p_ff[AW-1:0];
            ord_wdata = v_ff;
            jj_in     = jj_ff + IW'(1);
            state_in  = isqs_pkg::ST_IN0;
         end
         // pop the next range
         isqs_pkg::ST_POP0: begin
            if (sp_ff == '0) begin
               c_in     = '0;
               state_in = isqs_pkg::ST_OUT0;
            end else begin
               stk_raddr = SAW'(sp_ff - SW'(1));
               state_in  = isqs_pkg::ST_POP1;
            end
         end
         isqs_pkg::ST_POP1: begin
            r_in      = IW'(stk_q_ff);
            stk_raddr = SAW'(sp_ff - SW'(2));
            state_in  = isqs_pkg::ST_POP2;
         end
         isqs_pkg::ST_POP2: begin
            l_in     = IW'(stk_q_ff);
            sp_in    = sp_ff - SW'(2);
            state_in = isqs_pkg::ST_TEST;
         end
         // compare key of ord[cx] with key of ord[cy] or of cval
         isqs_pkg::ST_CMP0: begin
            ord_raddr = cx_ff[AW-1:0];
            state_in  = isqs_pkg::ST_CMP1;
         end
         isqs_pkg::ST_CMP1: begin
            key_raddr = ord_q_ff;
            vx_in     = ord_q_ff;
            ord_raddr = cy_ff[AW-1:0];
            state_in  = isqs_pkg::ST_CMP2;
         end
         isqs_pkg::ST_CMP2: begin
            ka_in     = key_q_ff;
            key_raddr = by_idx_ff ? ord_q_ff : cval_ff;
            state_in  = isqs_pkg::ST_CMP3;
         end
         isqs_pkg::ST_CMP3: begin
            gt_in    = desc_ff ? (key_q_ff > ka_ff) : (ka_ff > key_q_ff);
            lt_in    = desc_ff ? (key_q_ff < ka_ff) : (ka_ff < key_q_ff);
            state_in = ret_ff;
         end
         // swap ord[cx] and ord[cy]
         isqs_pkg::ST_SWP0: begin
            ord_raddr = cx_ff[AW-1:0];
            state_in  = isqs_pkg::ST_SWP1;
         end
         isqs_pkg::ST_SWP1: begin
            tx_in     = ord_q_ff;
            ord_raddr = cy_ff[AW-1:0];
            state_in  = isqs_pkg::ST_SWP2;
         end
         isqs_pkg::ST_SWP2: begin
            ord_we    = 1'b1;
            ord_waddr = cx_ff[AW-1:0];
            ord_wdata = ord_q_ff;
            state_in  = isqs_pkg::ST_SWP3;
         end
         isqs_pkg::ST_SWP3: begin
            ord_we    = 1'b1;
            ord_waddr = cy_ff[AW-1:0];
            ord_wdata = tx_ff;
            state_in  = ret_ff;
         end
         // read out sorted positions
         isqs_pkg::ST_OUT0: begin
            ord_raddr = c_ff[AW-1:0];
            state_in  = isqs_pkg::ST_OUT1;
         end
         isqs_pkg::ST_OUT1: begin
            rsp_strobe = 1'b1;
            c_in       = c_ff + IW'(1);
            if (c_ff + IW'(1) == n_ff) begin
               count_in = '0;
               state_in = isqs_pkg::ST_IDLE;
            end else begin
               state_in = isqs_pkg::ST_OUT0;
            end
         end
         default: state_in = isqs_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= isqs_pkg::ST_IDLE;
         ret_ff    <= isqs_pkg::ST_IDLE;
         desc_ff   <= 1'b0;
         count_ff  <= '0;
         n_ff      <= '0;
         c_ff      <= '0;
         l_ff      <= '0;
         r_ff      <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         jj_ff     <= '0;
         p_ff      <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         sp_ff     <= '0;
         by_idx_ff <= 1'b0;
         gt_ff     <= 1'b0;
         lt_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         if (csr_valid && csr_ready) begin
            desc_ff <= csr_descending;
         end
         count_ff  <= count_in;
         n_ff      <= n_in;
         c_ff      <= c_in;
         l_ff      <= l_in;
         r_ff      <= r_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         jj_ff     <= jj_in;
         p_ff      <= p_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         sp_ff     <= sp_in;
         by_idx_ff <= by_idx_in;
         gt_ff     <= gt_in;
         lt_ff     <= lt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cval_ff <= cval_in;
      vx_ff   <= vx_in;
      tx_ff   <= tx_in;
      a_ff    <= a_in;
      v_ff    <= v_in;
      ka_ff   <= ka_in;
      pl_ff   <= pl_in;
      ph_ff   <= ph_in;
   end

   // key memory
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_q_ff <= key_mem[key_raddr];
   end

   // order memory
   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
      ord_q_ff <= ord_mem[ord_raddr];
   end

   // range stack memory
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_q_ff <= stk_mem[stk_raddr];
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the index sort quicksort unit.
// ----------------------------------------------------------------------------
// Key sets are loaded into the unit, and each set ends on a transaction
// marked last. A model of the sorter inside this bench works out the expected
// sorted load positions of every set in both sort directions. Each result
// strobe is checked against the oldest expected position. The tests cover
// single and two-key sets, the key extremes, ties, store overflow and random
// sets. Random gaps are placed between transactions.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NKEYS    = 64;
   localparam int CUTOFF   = 7;
   localparam int STK      = 16;
   localparam int WD_LIMIT = 200000;
   localparam int SETTLE   = 40;

   typedef struct packed {
      logic [isqs_pkg::POS_W-1:0] position;
      logic                       last_position;
   } rank_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic signed [isqs_pkg::KEY_W-1:0] req_key;
   logic                              req_last_key;
   logic                              rsp_strobe;
   logic [isqs_pkg::POS_W-1:0]        rsp_position;
   logic                              rsp_last_position;
   logic                              csr_valid;
   logic                              csr_ready;
   logic                              csr_descending;

   // sorter model state
   logic [isqs_pkg::KEY_W-1:0] key_mem [NKEYS];
   int                         rank_mem [NKEYS];
   int                         bound_stk [STK];
   int                         keys_held;
   bit                         sort_down;

   rank_type ranks_due[$];
   int       err_count;
   int       idle_cycles;

   index_sort_quicksort_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_key           (req_key),
      .req_last_key      (req_last_key),
      .rsp_strobe        (rsp_strobe),
      .rsp_position      (rsp_position),
      .rsp_last_position (rsp_last_position),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_descending    (csr_descending)
   );

   always #1 clock = ~clock;

   // ---- sorter model ----
   // keys are held with the sign bit flipped, so unsigned compare is signed
   function automatic int key_order(int x, int y);
      logic [isqs_pkg::KEY_W-1:0] a, b;
      int t;
      if (sort_down) begin
         t = x; x = y; y = t;
      end
      a = key_mem[x];
      b = key_mem[y];
      return (a < b) ? -1 : ((a > b) ? 1 : 0);
   endfunction

   function automatic void swap_ranks(int x, int y);
      int t;
      t = rank_mem[x];
      rank_mem[x] = rank_mem[y];
      rank_mem[y] = t;
   endfunction

   function automatic void insert_sort(int l, int r);
      int i, j, v;
      for (j = l + 1; j <= r; j++) begin
         v = rank_mem[j];
         for (i = j - 1; i >= l; i--) begin
            if (key_order(rank_mem[i], v) <= 0) break;
            rank_mem[i + 1] = rank_mem[i];
         end
         rank_mem[i + 1] = v;
      end
   endfunction

   function automatic void sort_ranks(int n);
      int l, r, sp, i, j, k, a;
      l = 0; r = n - 1; sp = 0;
      forever begin
         if (r - l < CUTOFF || r - l < 2 || sp + 2 > STK) begin
            insert_sort(l, r);
            if (sp == 0) break;
            sp--; r = bound_stk[sp];
            sp--; l = bound_stk[sp];
            continue;
         end
         // median of three
         k = (l + r) >> 1;
         swap_ranks(k, l + 1);
         if (key_order(rank_mem[l + 1], rank_mem[r]) > 0) swap_ranks(l + 1, r);
         if (key_order(rank_mem[l], rank_mem[r]) > 0) swap_ranks(l, r);
         if (key_order(rank_mem[l + 1], rank_mem[l]) > 0) swap_ranks(l + 1, l);
         i = l + 1;
         j = r;
         a = rank_mem[l];
         // partition scans
         forever begin
            do i++; while (i < r && key_order(rank_mem[i], a) < 0);
            do j--; while (j > l && key_order(rank_mem[j], a) > 0);
            if (j < i) break;
            swap_ranks(i, j);
         end
         rank_mem[l] = rank_mem[j];
         rank_mem[j] = a;
         // larger side waits on the stack
         if (r - i + 1 >= j - l) begin
            bound_stk[sp++] = i;
            bound_stk[sp++] = r;
            r = j - 1;
         end else begin
            bound_stk[sp++] = l;
            bound_stk[sp++] = j - 1;
            l = i;
         end
      end
   endfunction

   // one accepted key transaction
   function automatic void load_key(logic [isqs_pkg::KEY_W-1:0] key, logic last);
      rank_type e;
      if (keys_held < NKEYS) begin
         key_mem[keys_held] = key ^ isqs_pkg::SIGN_FLIP;
         keys_held++;
      end
      if (!last) return;
      for (int r = 0; r < keys_held; r++) rank_mem[r] = r;
      sort_ranks(keys_held);
      for (int r = 0; r < keys_held; r++) begin
         e.position      = rank_mem[r][isqs_pkg::POS_W-1:0];
         e.last_position = (r == keys_held - 1);
         ranks_due.push_back(e);
      end
      keys_held = 0;
   endfunction

   // ---- checking ----
   task automatic report(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   always @(posedge clock) begin
      rank_type e;
      if (!reset && rsp_strobe) begin
         if (ranks_due.size() == 0) begin
            report($sformatf("unexpected result position %0d", rsp_position));
         end else begin
            e = ranks_due.pop_front();
            if (rsp_position !== e.position)
               report($sformatf("position %0d, expected %0d", rsp_position, e.position));
            if (rsp_last_position !== e.last_position)
               report($sformatf("last_position %0b, expected %0b",
                                rsp_last_position, e.last_position));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WD_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---- stimulus ----
   function automatic int pick_gap();
      if ($urandom_range(3) != 0) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(60, 20);
      return $urandom_range(3, 1);
   endfunction

   // entered and left at a falling edge
   task automatic send_key(logic [isqs_pkg::KEY_W-1:0] key, logic last, int gap);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start        = 1'b1;
      req_key      = key;
      req_last_key = last;
      do @(posedge clock); while (busy);
      load_key(key, last);
      @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      while (ranks_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_order(bit down);
      drain();
      csr_valid      = 1'b1;
      csr_descending = down;
      do @(posedge clock); while (!csr_ready);
      sort_down = down;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_set(int n, int spread);
      logic [isqs_pkg::KEY_W-1:0] k;
      for (int i = 0; i < n; i++) begin
         if (spread == 0) k = $urandom;
         else k = $urandom_range(spread) - spread / 2;
         send_key(k, i == n - 1, pick_gap());
      end
   endtask

   // extremes, single key, ties
   task automatic test_directed();
      send_key(32'h8000_0000, 1'b1, 0);
      send_key(32'h7fff_ffff, 1'b0, 0);
      send_key(32'h8000_0000, 1'b1, 0);
      send_key(32'h0000_0000, 1'b0, 2);
      send_key(32'hffff_ffff, 1'b0, 0);
      send_key(32'h0000_0001, 1'b0, 0);
      send_key(32'h7fff_ffff, 1'b0, 0);
      send_key(32'h8000_0000, 1'b1, 0);
      // all equal keys
      for (int i = 0; i < 9; i++) send_key(32'h0000_0005, i == 8, 0);
      // already ordered run
      for (int i = 0; i < 8; i++) send_key(i * 3 - 10, i == 7, 0);
   endtask

   // both directions, including reversed runs and a narrow-spread random set
   task automatic test_direction();
      write_order(1'b1);
      for (int i = 0; i < 8; i++) send_key(i, i == 7, 0);
      send_set(10, 6);
      write_order(1'b0);
      for (int i = 0; i < 8; i++) send_key(100 - i, i == 7, 0);
   endtask

   // a full store, then keys past the end that are dropped
   task automatic test_store_full();
      for (int i = 0; i < NKEYS + 2; i++) send_key($urandom, i == NKEYS + 1, pick_gap());
   endtask

   task automatic test_random();
      int sent;
      sent = 0;
      while (sent < 10) begin
         int n;
         if ($urandom_range(4) == 0) write_order(1'($urandom_range(1)));
         n = $urandom_range(12, 1);
         send_set(n, ($urandom_range(1) == 0) ? 0 : $urandom_range(20, 1));
         sent += n;
      end
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_key        = '0;
      req_last_key   = 1'b0;
      csr_valid      = 1'b0;
      csr_descending = 1'b0;
      keys_held      = 0;
      sort_down      = 1'b0;
      err_count      = 0;
      idle_cycles    = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_direction();
      test_store_full();
      test_random();
      drain();

      if (err_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
